### hdl/clock_tick_runtime_accounting_top_defines.svh
// Assertion macros shared by the accounting block.
`ifndef CLOCK_TICK_RUNTIME_ACCOUNTING_TOP_DEFINES_SVH
`define CLOCK_TICK_RUNTIME_ACCOUNTING_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctra: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CTRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctra: next-cycle check failed");

`endif

### hdl/ctra_pkg.sv
package ctra_pkg;

    // Counter width default
    localparam int COUNTER_WIDTH_DEF = 32;

    // Configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEFER_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TUNE_PERIOD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IDEAL_RATE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUANTUM_STEP   = 3'd4;

    // Register reset values
    localparam logic [4:0]  DEFER_LEVEL_RST    = 5'd2;
    localparam logic [7:0]  TUNE_PERIOD_RST    = 8'd20;
    localparam logic [15:0] IDEAL_RATE_RST     = 16'd20;
    localparam logic [7:0]  DEPTH_LIMIT_RST    = 8'd4;
    localparam logic [6:0]  QUANTUM_STEP_RST   = 7'd3;

    // Saturation floor of the quantum
    localparam logic [7:0]  QUANTUM_FLOOR      = 8'h80;

    typedef struct packed {
        logic [4:0]  defer_level;
        logic [7:0]  tune_period;
        logic [15:0] ideal_rate;
        logic [7:0]  depth_limit;
        logic [6:0]  quantum_step;
    } t_cfg;

    typedef struct packed {
        logic              from_user_mode;
        logic [4:0]        run_level;
        logic              deferred_routine_active;
        logic              deferred_irq_requested;
        logic              deferred_queue_nonempty;
        logic [31:0]       deferred_total_count;
        logic signed [7:0] thread_quantum;
        logic              thread_is_idle;
    } t_item;

    typedef struct packed {
        logic signed [7:0] new_quantum;
        logic              charge_user;
        logic              charge_kernel;
        logic              dispatch_request;
        logic [31:0]       request_rate;
        logic [7:0]        max_queue_depth;
        logic [31:0]       interrupt_total;
        logic [31:0]       cpu_user_ticks;
        logic [31:0]       cpu_kernel_ticks;
        logic [31:0]       cpu_hw_interrupt_ticks;
        logic [31:0]       cpu_deferred_ticks;
    } t_result;

endpackage

### hdl/ctra_cfg_regs.sv
module ctra_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ctra_pkg::CFG_INDEX_W-1:0]   i_index,
    input  logic [ctra_pkg::CFG_DATA_W-1:0]    i_data,
    output ctra_pkg::t_cfg                     o_cfg
);

    ctra_pkg::t_cfg r_cfg;
    ctra_pkg::t_cfg n_cfg;

    // Always take writes
    assign o_ready = 1'b1;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (i_index)
                ctra_pkg::REG_DEFER_LEVEL:    n_cfg.defer_level    = i_data[4:0];
                ctra_pkg::REG_TUNE_PERIOD:    n_cfg.tune_period    = i_data[7:0];
                ctra_pkg::REG_IDEAL_RATE:     n_cfg.ideal_rate     = i_data[15:0];
                ctra_pkg::REG_DEPTH_LIMIT:    n_cfg.depth_limit    = i_data[7:0];
                ctra_pkg::REG_QUANTUM_STEP:   n_cfg.quantum_step   = i_data[6:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.defer_level    <= ctra_pkg::DEFER_LEVEL_RST;
            r_cfg.tune_period    <= ctra_pkg::TUNE_PERIOD_RST;
            r_cfg.ideal_rate     <= ctra_pkg::IDEAL_RATE_RST;
            r_cfg.depth_limit    <= ctra_pkg::DEPTH_LIMIT_RST;
            r_cfg.quantum_step   <= ctra_pkg::QUANTUM_STEP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/ctra_tick_core.sv
module ctra_tick_core #(
    parameter int COUNTER_WIDTH = ctra_pkg::COUNTER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  ctra_pkg::t_item   i_item,
    input  ctra_pkg::t_cfg    i_cfg,
    output ctra_pkg::t_result o_result
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    logic [COUNTER_WIDTH-1:0] r_tick, r_user, r_kernel, r_hw, r_deferred;
    logic [COUNTER_WIDTH-1:0] n_tick, n_user, n_kernel, n_hw, n_deferred;
    logic [31:0]              r_rate, n_rate, r_last_total;
    logic [7:0]               r_countdown, n_countdown, countdown_dec;
    logic [7:0]               r_depth, n_depth;

    logic       charge_kernel;
    logic       run_hw;
    logic       tune_hit;
    logic [8:0] quantum_diff;
    logic [7:0] quantum_new;
    logic       quantum_sat;
    logic       quantum_out;

    // Classify the tick
    assign charge_kernel = !i_item.from_user_mode &&
                           ((i_item.run_level < i_cfg.defer_level) ||
                            !i_item.deferred_routine_active);
    assign run_hw        = i_item.run_level > i_cfg.defer_level;

    always_comb begin
        n_tick     = r_tick + CNT_ONE;
        n_user     = r_user;
        n_kernel   = r_kernel;
        n_hw       = r_hw;
        n_deferred = r_deferred;
        if (i_item.from_user_mode) begin
            n_user = r_user + CNT_ONE;
        end else begin
            n_kernel = r_kernel + CNT_ONE;
            if (!charge_kernel) begin
                if (run_hw) begin
                    n_hw = r_hw + CNT_ONE;
                end else begin
                    n_deferred = r_deferred + CNT_ONE;
                end
            end
        end
    end

    // Average the request rate, wrapping before the halving
    always_comb begin
        n_rate = ((i_item.deferred_total_count - r_last_total) + r_rate) >> 1;
    end

    // Tune the queue depth
    assign tune_hit      = i_item.deferred_queue_nonempty &&
                           !i_item.deferred_routine_active &&
                           !i_item.deferred_irq_requested;
    assign countdown_dec = r_countdown - 8'd1;

    always_comb begin
        n_countdown = countdown_dec;
        n_depth     = r_depth;
        if (tune_hit) begin
            n_countdown = i_cfg.tune_period;
            if ((n_rate < {16'd0, i_cfg.ideal_rate}) && (r_depth > 8'd1)) begin
                n_depth = r_depth - 8'd1;
            end
        end else if (countdown_dec == 8'd0) begin
            n_countdown = i_cfg.tune_period;
            if (r_depth < i_cfg.depth_limit) begin
                n_depth = r_depth + 8'd1;
            end
        end
    end

    // Decrement the quantum, saturate at the floor
    assign quantum_diff = {i_item.thread_quantum[7], i_item.thread_quantum} -
                          {2'b00, i_cfg.quantum_step};
    assign quantum_sat  = quantum_diff[8] && !quantum_diff[7];
    assign quantum_new  = quantum_sat ? ctra_pkg::QUANTUM_FLOOR : quantum_diff[7:0];
    assign quantum_out  = (quantum_new[7] || (quantum_new == 8'd0)) &&
                          !i_item.thread_is_idle;

    // Assemble the result
    always_comb begin
        o_result.new_quantum            = quantum_new;
        o_result.charge_user            = i_item.from_user_mode;
        o_result.charge_kernel          = charge_kernel;
        o_result.dispatch_request       = tune_hit || quantum_out;
        o_result.request_rate           = n_rate;
        o_result.max_queue_depth        = n_depth;
        o_result.interrupt_total        = 32'(n_tick);
        o_result.cpu_user_ticks         = 32'(n_user);
        o_result.cpu_kernel_ticks       = 32'(n_kernel);
        o_result.cpu_hw_interrupt_ticks = 32'(n_hw);
        o_result.cpu_deferred_ticks     = 32'(n_deferred);
    end

    // Commit state once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_user       <= '0;
            r_kernel     <= '0;
            r_hw         <= '0;
            r_deferred   <= '0;
            r_rate       <= '0;
            r_last_total <= '0;
            r_countdown  <= ctra_pkg::TUNE_PERIOD_RST;
            r_depth      <= ctra_pkg::DEPTH_LIMIT_RST;
        end else if (i_advance) begin
            r_tick       <= n_tick;
            r_user       <= n_user;
            r_kernel     <= n_kernel;
            r_hw         <= n_hw;
            r_deferred   <= n_deferred;
            r_rate       <= n_rate;
            r_last_total <= i_item.deferred_total_count;
            r_countdown  <= n_countdown;
            r_depth      <= n_depth;
        end
    end

endmodule

### hdl/clock_tick_runtime_accounting_top.sv
// Channel   Handshake                  Payload
// tick in   i_in_valid / o_in_stall    i_from_user_mode .. i_thread_is_idle
// result    o_out_valid / i_out_stall  o_new_quantum .. o_cpu_deferred_ticks
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while the result is not stalled; a taken item passes from
// the input register to the result register, which holds the accounting update.
// Reset is synchronous, active low; it restores counters and registers.
// A stalled result holds; the input register still takes one more item.
// Config writes are always ready.
`include "clock_tick_runtime_accounting_top_defines.svh"

module clock_tick_runtime_accounting_top #(
    parameter int COUNTER_WIDTH = ctra_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_from_user_mode,
    input  logic [4:0]                       i_run_level,
    input  logic                             i_deferred_routine_active,
    input  logic                             i_deferred_irq_requested,
    input  logic                             i_deferred_queue_nonempty,
    input  logic [31:0]                      i_deferred_total_count,
    input  logic signed [7:0]                i_thread_quantum,
    input  logic                             i_thread_is_idle,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [7:0]                o_new_quantum,
    output logic                             o_charge_user,
    output logic                             o_charge_kernel,
    output logic                             o_dispatch_request,
    output logic [31:0]                      o_request_rate,
    output logic [7:0]                       o_max_queue_depth,
    output logic [31:0]                      o_interrupt_total,
    output logic [31:0]                      o_cpu_user_ticks,
    output logic [31:0]                      o_cpu_kernel_ticks,
    output logic [31:0]                      o_cpu_hw_interrupt_ticks,
    output logic [31:0]                      o_cpu_deferred_ticks,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctra_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ctra_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ctra_pkg::t_cfg    cfg;
    ctra_pkg::t_item   r_item;
    ctra_pkg::t_result r_result;
    ctra_pkg::t_result core_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              out_free;
    logic              advance;
    logic              in_take;

    ctra_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Move an item to the result register when that register frees up
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    ctra_tick_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    // Hold the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (out_free || !r_in_valid) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.from_user_mode          <= i_from_user_mode;
            r_item.run_level               <= i_run_level;
            r_item.deferred_routine_active <= i_deferred_routine_active;
            r_item.deferred_irq_requested  <= i_deferred_irq_requested;
            r_item.deferred_queue_nonempty <= i_deferred_queue_nonempty;
            r_item.deferred_total_count    <= i_deferred_total_count;
            r_item.thread_quantum          <= i_thread_quantum;
            r_item.thread_is_idle          <= i_thread_is_idle;
        end
    end

    // Hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_new_quantum            = r_result.new_quantum;
    assign o_charge_user            = r_result.charge_user;
    assign o_charge_kernel          = r_result.charge_kernel;
    assign o_dispatch_request       = r_result.dispatch_request;
    assign o_request_rate           = r_result.request_rate;
    assign o_max_queue_depth        = r_result.max_queue_depth;
    assign o_interrupt_total        = r_result.interrupt_total;
    assign o_cpu_user_ticks         = r_result.cpu_user_ticks;
    assign o_cpu_kernel_ticks       = r_result.cpu_kernel_ticks;
    assign o_cpu_hw_interrupt_ticks = r_result.cpu_hw_interrupt_ticks;
    assign o_cpu_deferred_ticks     = r_result.cpu_deferred_ticks;

    // A tick is never charged to both user and kernel time
    `CTRA_ASSERT_NOW(a_charge_excl, i_clk, i_rst_n, o_out_valid, !(o_charge_user && o_charge_kernel))
    // The queue depth never reaches zero
    `CTRA_ASSERT_NOW(a_depth_nonzero, i_clk, i_rst_n, o_out_valid, o_max_queue_depth != 8'd0)
    // Input stalls only with both registers full
    `CTRA_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)
    // A moved item always shows up as a valid result
    `CTRA_ASSERT_NEXT(a_advance_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // tick channel
    logic            tick_valid = 1'b0;
    logic            tick_stall;
    ctra_pkg::t_item tick_q = '0;

    // result channel
    logic              res_valid;
    logic              res_stall = 1'b0;
    ctra_pkg::t_result res_port;

    // configuration channel
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ctra_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ctra_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // register copies, updated as writes land
    logic [4:0]  cfg_defer_level    = ctra_pkg::DEFER_LEVEL_RST;
    logic [7:0]  cfg_tune_period    = ctra_pkg::TUNE_PERIOD_RST;
    logic [15:0] cfg_ideal_rate     = ctra_pkg::IDEAL_RATE_RST;
    logic [7:0]  cfg_depth_limit    = ctra_pkg::DEPTH_LIMIT_RST;
    logic [6:0]  cfg_quantum_step   = ctra_pkg::QUANTUM_STEP_RST;

    // accounting state as the block should hold it
    logic [31:0] ticks_total     = '0;
    logic [31:0] ticks_user      = '0;
    logic [31:0] ticks_kernel    = '0;
    logic [31:0] ticks_hw_irq    = '0;
    logic [31:0] ticks_deferred  = '0;
    logic [31:0] rate_avg        = '0;
    logic [31:0] last_total      = '0;
    logic [7:0]  tune_countdown  = ctra_pkg::TUNE_PERIOD_RST;
    logic [7:0]  depth_ceiling   = ctra_pkg::DEPTH_LIMIT_RST;

    ctra_pkg::t_item   pending_ticks[$];
    ctra_pkg::t_result expected_results[$];

    int unsigned mismatch_count = 0;
    int unsigned result_index = 0;
    int          send_wait = 0;
    int          stall_left = 0;
    bit          send_calm = 1'b0;
    bit          sink_calm = 1'b0;
    int          queue_busy_pct = 66;
    logic [31:0] gen_total = '0;

    clock_tick_runtime_accounting_top dut (
        .i_clk                    (clk),
        .i_rst_n                  (rst_n),
        .i_in_valid               (tick_valid),
        .o_in_stall               (tick_stall),
        .i_from_user_mode         (tick_q.from_user_mode),
        .i_run_level              (tick_q.run_level),
        .i_deferred_routine_active(tick_q.deferred_routine_active),
        .i_deferred_irq_requested (tick_q.deferred_irq_requested),
        .i_deferred_queue_nonempty(tick_q.deferred_queue_nonempty),
        .i_deferred_total_count   (tick_q.deferred_total_count),
        .i_thread_quantum         (tick_q.thread_quantum),
        .i_thread_is_idle         (tick_q.thread_is_idle),
        .o_out_valid              (res_valid),
        .i_out_stall              (res_stall),
        .o_new_quantum            (res_port.new_quantum),
        .o_charge_user            (res_port.charge_user),
        .o_charge_kernel          (res_port.charge_kernel),
        .o_dispatch_request       (res_port.dispatch_request),
        .o_request_rate           (res_port.request_rate),
        .o_max_queue_depth        (res_port.max_queue_depth),
        .o_interrupt_total        (res_port.interrupt_total),
        .o_cpu_user_ticks         (res_port.cpu_user_ticks),
        .o_cpu_kernel_ticks       (res_port.cpu_kernel_ticks),
        .o_cpu_hw_interrupt_ticks (res_port.cpu_hw_interrupt_ticks),
        .o_cpu_deferred_ticks     (res_port.cpu_deferred_ticks),
        .i_cfg_valid              (cfg_valid),
        .o_cfg_ready              (cfg_ready),
        .i_cfg_index              (cfg_index),
        .i_cfg_data               (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Charge one tick and return what the block should report for it
    function automatic ctra_pkg::t_result account_tick(input ctra_pkg::t_item t);
        ctra_pkg::t_result r;
        int                q;
        logic [31:0]       rate_sum;
        r = '0;
        ticks_total++;
        if (t.from_user_mode) begin
            r.charge_user = 1'b1;
            ticks_user++;
        end else begin
            ticks_kernel++;
            if (t.run_level < cfg_defer_level || !t.deferred_routine_active)
                r.charge_kernel = 1'b1;
            else if (t.run_level > cfg_defer_level)
                ticks_hw_irq++;
            else
                ticks_deferred++;
        end

        // moving average: the sum wraps before the halving
        rate_sum = (t.deferred_total_count - last_total) + rate_avg;
        rate_avg = rate_sum >> 1;
        last_total = t.deferred_total_count;

        // queue depth tuning
        if (t.deferred_queue_nonempty && !t.deferred_routine_active &&
            !t.deferred_irq_requested) begin
            tune_countdown = cfg_tune_period;
            r.dispatch_request = 1'b1;
            if (rate_avg < {16'd0, cfg_ideal_rate} && depth_ceiling > 8'd1)
                depth_ceiling = depth_ceiling - 8'd1;
        end else begin
            tune_countdown = tune_countdown - 8'd1;
            if (tune_countdown == 8'd0) begin
                tune_countdown = cfg_tune_period;
                if (depth_ceiling < cfg_depth_limit)
                    depth_ceiling = depth_ceiling + 8'd1;
            end
        end

        // quantum, floored at the most negative value
        q = $signed(t.thread_quantum);
        q = q - int'(cfg_quantum_step);
        if (q < -128)
            q = -128;
        if (q <= 0 && !t.thread_is_idle)
            r.dispatch_request = 1'b1;

        r.new_quantum            = q[7:0];
        r.request_rate           = rate_avg;
        r.max_queue_depth        = depth_ceiling;
        r.interrupt_total        = ticks_total;
        r.cpu_user_ticks         = ticks_user;
        r.cpu_kernel_ticks       = ticks_kernel;
        r.cpu_hw_interrupt_ticks = ticks_hw_irq;
        r.cpu_deferred_ticks     = ticks_deferred;
        return r;
    endfunction

    // Wait before the next item: random, with calm stretches of none
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d, %s: got %h, expected %h",
                 result_index, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Track register writes as they land
    always @(posedge clk) begin
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                ctra_pkg::REG_DEFER_LEVEL:  cfg_defer_level <= cfg_data[4:0];
                ctra_pkg::REG_TUNE_PERIOD:  cfg_tune_period <= cfg_data[7:0];
                ctra_pkg::REG_IDEAL_RATE:   cfg_ideal_rate <= cfg_data[15:0];
                ctra_pkg::REG_DEPTH_LIMIT:  cfg_depth_limit <= cfg_data[7:0];
                ctra_pkg::REG_QUANTUM_STEP: cfg_quantum_step <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Driver: predict each accepted tick, then present the next one
    always @(posedge clk) begin : drive_ticks
        bit              took;
        ctra_pkg::t_item next_tick;
        if (rst_n) begin
            took = tick_valid && !tick_stall;
            if (took)
                expected_results.push_back(account_tick(tick_q));
            if (!tick_valid || took) begin
                if (send_wait > 0) begin
                    send_wait--;
                    tick_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    next_tick = pending_ticks.pop_front();
                    tick_q <= next_tick;
                    tick_valid <= 1'b1;
                    send_wait = draw_wait(send_calm);
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result, then stall at random
    always @(posedge clk) begin : watch_results
        ctra_pkg::t_result want;
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no tick pending", '0, '0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("new_quantum", res_port.new_quantum, want.new_quantum);
                    check_field("charge_user", res_port.charge_user, want.charge_user);
                    check_field("charge_kernel", res_port.charge_kernel, want.charge_kernel);
                    check_field("dispatch_request", res_port.dispatch_request,
                                want.dispatch_request);
                    check_field("request_rate", res_port.request_rate, want.request_rate);
                    check_field("max_queue_depth", res_port.max_queue_depth,
                                want.max_queue_depth);
                    check_field("interrupt_total", res_port.interrupt_total,
                                want.interrupt_total);
                    check_field("cpu_user_ticks", res_port.cpu_user_ticks,
                                want.cpu_user_ticks);
                    check_field("cpu_kernel_ticks", res_port.cpu_kernel_ticks,
                                want.cpu_kernel_ticks);
                    check_field("cpu_hw_interrupt_ticks", res_port.cpu_hw_interrupt_ticks,
                                want.cpu_hw_interrupt_ticks);
                    check_field("cpu_deferred_ticks", res_port.cpu_deferred_ticks,
                                want.cpu_deferred_ticks);
                end
                result_index++;
                stall_left = draw_wait(sink_calm);
            end
            if (stall_left > 0) begin
                res_stall <= 1'b1;
                stall_left--;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    task automatic push_tick(input bit user, input bit [4:0] level, input bit active,
                             input bit irq, input bit nonempty, input bit [31:0] total,
                             input bit [7:0] quantum, input bit idle);
        ctra_pkg::t_item t;
        t.from_user_mode          = user;
        t.run_level               = level;
        t.deferred_routine_active = active;
        t.deferred_irq_requested  = irq;
        t.deferred_queue_nonempty = nonempty;
        t.deferred_total_count    = total;
        t.thread_quantum          = quantum;
        t.thread_is_idle          = idle;
        pending_ticks.push_back(t);
    endtask

    // Random tick: levels near the deferred-call level, totals mostly creeping up
    function automatic ctra_pkg::t_item make_tick();
        ctra_pkg::t_item t;
        int              pick;
        t.from_user_mode = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 3))
            0: t.run_level = cfg_defer_level;
            1: t.run_level = cfg_defer_level - 5'd1;
            2: t.run_level = cfg_defer_level + 5'd1;
            default: t.run_level = 5'($urandom);
        endcase
        t.deferred_routine_active = $urandom_range(0, 1);
        t.deferred_irq_requested  = ($urandom_range(0, 3) == 0);
        t.deferred_queue_nonempty = ($urandom_range(0, 99) < queue_busy_pct);
        pick = $urandom_range(0, 29);
        if (pick == 0)
            gen_total = $urandom;
        else if (pick == 1)
            gen_total = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else if (pick == 2)
            gen_total = gen_total - $urandom_range(1, 50);
        else
            gen_total = gen_total + $urandom_range(0, 40);
        t.deferred_total_count = gen_total;
        case ($urandom_range(0, 3))
            0: t.thread_quantum = 8'($urandom);
            1: t.thread_quantum = 8'($urandom_range(128, 135));
            2: t.thread_quantum = 8'(int'(cfg_quantum_step) + $urandom_range(0, 4) - 2);
            default: t.thread_quantum = 8'($urandom_range(0, 16) - 8);
        endcase
        t.thread_is_idle = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    task automatic add_random_ticks(input int count);
        for (int n = 0; n < count; n++)
            pending_ticks.push_back(make_tick());
    endtask

    // Hold until every tick is accepted and every result is back
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || tick_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ctra_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ctra_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int level, input int period, input int ideal,
                              input int limit, input int step);
        write_reg(ctra_pkg::REG_DEFER_LEVEL, ctra_pkg::CFG_DATA_W'(level));
        write_reg(ctra_pkg::REG_TUNE_PERIOD, ctra_pkg::CFG_DATA_W'(period));
        write_reg(ctra_pkg::REG_IDEAL_RATE, ctra_pkg::CFG_DATA_W'(ideal));
        write_reg(ctra_pkg::REG_DEPTH_LIMIT, ctra_pkg::CFG_DATA_W'(limit));
        write_reg(ctra_pkg::REG_QUANTUM_STEP, ctra_pkg::CFG_DATA_W'(step));
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks under the reset settings
        push_tick(1, 0, 0, 0, 0, 32'd0, 8'h7F, 0);           // user mode, largest quantum
        push_tick(0, 1, 1, 0, 0, 32'd5, 8'd10, 0);           // below deferred-call level
        push_tick(0, 2, 1, 0, 0, 32'd9, 8'd10, 0);           // at level: deferred time
        push_tick(0, 3, 1, 0, 0, 32'd9, 8'd10, 0);           // above level: hw irq time
        push_tick(0, 31, 1, 1, 1, 32'd12, 8'd10, 0);         // queue busy, irq pending
        push_tick(0, 31, 0, 0, 0, 32'd12, 8'd10, 0);         // no routine: kernel time
        push_tick(0, 2, 0, 0, 1, 32'd40, 8'd10, 0);          // queue drain request
        push_tick(0, 0, 1, 0, 1, 32'd41, 8'd10, 0);          // busy while routine runs
        push_tick(1, 0, 0, 0, 1, 32'hFFFF_FFFF, 8'd10, 0);   // huge jump in total
        push_tick(1, 0, 0, 1, 1, 32'hFFFF_FFFF, 8'd10, 0);
        push_tick(0, 0, 0, 0, 0, 32'hEFFF_FFFF, 8'd10, 0);   // rate sum wraps
        push_tick(0, 0, 0, 0, 0, 32'd3, 8'h80, 0);           // quantum at floor
        push_tick(0, 0, 0, 0, 0, 32'd3, 8'h82, 1);           // clamp to floor, idle
        push_tick(0, 0, 0, 0, 0, 32'd4, 8'd3, 0);            // exhausted exactly
        push_tick(0, 0, 0, 0, 0, 32'd4, 8'd4, 0);            // one unit left
        push_tick(0, 0, 0, 0, 0, 32'd4, 8'd0, 1);            // idle thread exhausted
        push_tick(0, 0, 0, 0, 0, 32'd4, 8'hFF, 0);
        push_tick(1, 31, 1, 1, 0, 32'd4, 8'h7F, 1);
        for (int n = 0; n < 6; n++)
            push_tick(0, 5'(n), 1, 0, 0, 32'd4, 8'd60, 0);   // idle ticks toward a raise
        wait_drained();

        // shortest period, widest ceiling, nothing counted as slow
        set_config(0, 1, 0, 255, 0);
        gen_total = 32'd100;
        add_random_ticks(250);
        wait_drained();

        // other extremes: ceiling now far above the limit
        set_config(31, 255, 65535, 1, 127);
        add_random_ticks(250);
        wait_drained();

        // zero period wraps the countdown: keep the queue empty to get there
        set_config(2, 0, 30, 8, 3);
        queue_busy_pct = 0;
        add_random_ticks(300);
        wait_drained();
        queue_busy_pct = 66;

        for (int phase = 0; phase < 3; phase++) begin
            set_config($urandom_range(0, 31), $urandom_range(1, 12), $urandom_range(0, 60),
                       $urandom_range(1, 20), $urandom_range(0, 1) ? $urandom_range(0, 6)
                                                                   : $urandom_range(0, 127));
            add_random_ticks(230);
            wait_drained();
        end

        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #500000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
